### src/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int DEF_NUMBER_WIDTH = 32;
    localparam int PRIME_W          = 31;

    typedef enum logic [1:0] {
        VERDICT_LOW       = 2'd0,
        VERDICT_COMPOSITE = 2'd1,
        VERDICT_PRIME     = 2'd2
    } t_verdict;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

### src/tdp_rem_unit.sv
// ----------------------------------------------------------------------------
// tdp_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdp_rem_unit
    import tdp_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH,
    parameter int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]    i_divisor,
    output t_rem_status             o_status
);

    localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [NUMBER_WIDTH-1:0] r_dividend;
    logic [DIV_WIDTH-1:0]    r_divisor;
    logic [DIV_WIDTH-1:0]    r_rem;

    logic [DIV_WIDTH:0]      shifted;
    logic [DIV_WIDTH:0]      diff;
    logic [DIV_WIDTH-1:0]    n_rem;

    always_comb begin
        shifted = {r_rem, r_dividend[NUMBER_WIDTH-1]};
        diff    = shifted - {1'b0, r_divisor};
        if (shifted >= {1'b0, r_divisor}) begin
            n_rem = diff[DIV_WIDTH-1:0];
        end else begin
            n_rem = shifted[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUMBER_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[NUMBER_WIDTH-2:0], 1'b0};
            r_rem      <= n_rem;
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_divisor)
        else $error("remainder reached divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a pass");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("start while busy");

endmodule

### src/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Classifies a signed candidate as below two, composite or prime by trial
// division, and keeps the most recent prime.
// ----------------------------------------------------------------------------
// One candidate at a time: o_stall stays high from acceptance until the
// result is loaded into the output register. A negative, zero or one
// candidate is classified without any division. Otherwise divisors d = 2, 3, ...
// are tried while d*d <= n, each one in the bit-serial remainder unit,
// which shifts in one dividend bit per cycle. A full output register
// that waits downstream holds the result back in the done state.
// A new candidate is taken while the previous result still waits downstream.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_candidate,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_verdict,
    output logic [PRIME_W-1:0]      o_latest_prime
);

    localparam int DIV_WIDTH = (NUMBER_WIDTH + 1) / 2 + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state,  n_state;
    logic [NUMBER_WIDTH-1:0] r_num,    n_num;
    logic [DIV_WIDTH-1:0]    r_div,    n_div;
    logic [NUMBER_WIDTH-1:0] r_sq,     n_sq;
    t_verdict                r_result, n_result;
    logic [PRIME_W-1:0]      r_latest, n_latest;
    logic                    r_out_valid, n_out_valid;
    t_verdict                r_out_verdict, n_out_verdict;
    logic [PRIME_W-1:0]      r_out_prime, n_out_prime;

    logic                    start;
    t_rem_status             rem_status;
    logic                    in_beat;
    logic                    out_free;

    assign in_beat  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    tdp_rem_unit #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .DIV_WIDTH    (DIV_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (r_num),
        .i_divisor  (r_div),
        .o_status   (rem_status)
    );

    always_comb begin
        n_state       = r_state;
        n_num         = r_num;
        n_div         = r_div;
        n_sq          = r_sq;
        n_result      = r_result;
        n_latest      = r_latest;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_prime   = r_out_prime;
        start         = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_num = i_candidate;
                    n_div = DIV_WIDTH'(2);
                    n_sq  = NUMBER_WIDTH'(4);
                    if (i_candidate[NUMBER_WIDTH-1] || i_candidate <= NUMBER_WIDTH'(1)) begin
                        n_result = VERDICT_LOW;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > r_num) begin
                    n_result = VERDICT_PRIME;
                    n_state  = S_DONE;
                end else begin
                    start   = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        n_result = VERDICT_COMPOSITE;
                        n_state  = S_DONE;
                    end else begin
                        n_div   = r_div + DIV_WIDTH'(1);
                        n_sq    = r_sq + NUMBER_WIDTH'({r_div, 1'b1});
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_result == VERDICT_PRIME) begin
                        n_latest = PRIME_W'(r_num);
                    end
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_result;
                    n_out_prime   = (r_result == VERDICT_PRIME) ? PRIME_W'(r_num) : r_latest;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_latest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_latest    <= n_latest;
            r_out_valid <= n_out_valid;
        end
        r_num         <= n_num;
        r_div         <= n_div;
        r_sq          <= n_sq;
        r_result      <= n_result;
        r_out_verdict <= n_out_verdict;
        r_out_prime   <= n_out_prime;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_verdict      = r_out_verdict;
    assign o_latest_prime = r_out_prime;

    a_prime_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == VERDICT_PRIME) |-> r_out_prime != '0)
        else $error("prime beat without latest prime");

    a_div_within_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_sq <= r_num && r_div >= DIV_WIDTH'(2)))
        else $error("divisor beyond square root");

    a_start_only_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> (r_state == S_CHECK && !r_num[NUMBER_WIDTH-1]))
        else $error("division started outside check");

endmodule
